// ===== design/fixed_array_insert_remove_unit_macros.svh =====
// assertion helpers for the fixed array insert/remove unit
`ifndef FIXED_ARRAY_INSERT_REMOVE_UNIT_MACROS_SVH
`define FIXED_ARRAY_INSERT_REMOVE_UNIT_MACROS_SVH

// clocked check, quiet while reset is asserted
`define FAIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define FAIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fair_pkg.sv =====
`default_nettype none

package fair_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 7;
    localparam int GROUP     = 8;
    localparam int NGROUP    = (DEPTH + GROUP - 1) / GROUP;
    localparam int GCNT_W    = $clog2(GROUP + 1);

    // request kinds
    localparam logic [2:0] KIND_LOAD    = 3'd0;
    localparam logic [2:0] KIND_FILL    = 3'd1;
    localparam logic [2:0] KIND_REM_VAL = 3'd2;
    localparam logic [2:0] KIND_REM_IDX = 3'd3;
    localparam logic [2:0] KIND_ADD     = 3'd4;
    localparam logic [2:0] KIND_READ    = 3'd5;

    // add behavior on an occupied slot
    localparam logic [1:0] MODE_OVER    = 2'd0;
    localparam logic [1:0] MODE_SHIFT_L = 2'd1;
    localparam logic [1:0] MODE_SHIFT_R = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // result status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_MODE      = 3'd3;
    localparam logic [2:0] ST_NOTHING   = 3'd4;

    typedef logic [WORD_BITS-1:0] word_t;

    // operation broadcast along the cell row
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,
        OP_FILL,
        OP_CLEAR_MATCH,
        OP_SHIFT_L,
        OP_SHIFT_R
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        word_t            data;
    } cell_cmd_t;

    typedef struct packed {
        logic in_use;
        logic hit;
        logic empty;
    } cell_flags_t;

    // length register with 0 read as 1 and values above the depth clipped
    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [LEN_W-1:0] n;
        if (v == '0)
            n = LEN_W'(1);
        else if (int'(v) > DEPTH)
            n = LEN_W'(DEPTH);
        else
            n = LEN_W'(v);
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/fixed_array_insert_remove_unit.sv =====
// channel | direction | handshake              | tdata fields, lowest bit first
// s       | in        | s_tvalid / s_tready    | kind[3] index[6] value[32] mode[2], pad to 48
// m       | out       | m_tvalid / m_tready    | status[3] empty_count[7] read_value[32], pad to 48
// cfg     | in        | cfg_wen                | used_length[7]
//
// a request steps through capture, evaluate against the cell row, apply to the
// cells, then the group and sum registers of the zero-count tree before the result
// register loads; the next request is taken in the cycle after that
// the result register lets the next request in while the previous result waits
// rst_n clears the slots, sets used_length to 64 and empties the result register
// a stalled result holds the sequencer in done after the count, so the next request waits
`default_nettype none
`include "fixed_array_insert_remove_unit_macros.svh"

module fixed_array_insert_remove_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [6:0]  cfg_wdata,  // used_length
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,    // kind, index, value, mode, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata     // status, empty_count, read_value, zero pad
);

    localparam int DEPTH = fair_pkg::DEPTH;
    localparam int CMP_W = fair_pkg::LEN_W + 6;

    localparam logic [6:0] USED_LEN_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_CNT1,
        S_CNT2,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [6:0]                  used_len_reg;
    logic [2:0]                  kind_reg;
    logic [5:0]                  idx_reg;
    fair_pkg::word_t             value_reg;
    logic [1:0]                  mode_reg;
    fair_pkg::op_t               op_reg, op_next;
    fair_pkg::word_t             data_reg, data_next;
    logic [2:0]                  status_reg, status_next;
    logic [31:0]                 rd_reg, rd_next;
    logic                        m_tvalid_reg;
    logic [2:0]                  m_status_reg;
    logic [6:0]                  m_count_reg;
    logic [31:0]                 m_read_reg;

    logic [fair_pkg::LEN_W-1:0]  n;
    logic                        idx_ok;
    logic                        idx_last;
    logic                        tgt_occ;
    logic                        any_occ;
    fair_pkg::word_t             hit_word;
    logic                        s_accept;
    logic                        out_free;

    fair_pkg::cell_cmd_t         cell_cmd;
    fair_pkg::word_t             cell_word  [DEPTH];
    fair_pkg::cell_flags_t       cell_flags [DEPTH];
    logic [DEPTH-1:0]            empty_vec;
    logic [fair_pkg::LEN_W-1:0]  zero_count;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;
    assign n        = fair_pkg::eff_len(used_len_reg);

    // command broadcast to the row, moving only in the apply cycle
    assign cell_cmd.op   = (state_reg == S_APPLY) ? op_reg : fair_pkg::OP_HOLD;
    assign cell_cmd.idx  = fair_pkg::IDX_W'(idx_reg);
    assign cell_cmd.len  = n;
    assign cell_cmd.data = data_reg;

    // row of slot cells, each linked to both neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        fair_pkg::word_t left_w;
        fair_pkg::word_t right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_word[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_word[i+1];
        end

        fair_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (fair_pkg::IDX_W'(i)),
            .cmd        (cell_cmd),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (cell_word[i]),
            .flags      (cell_flags[i])
        );

        assign empty_vec[i] = cell_flags[i].empty;
    end

    fair_zcount u_zcount (
        .clk       (clk),
        .empty_vec (empty_vec),
        .count     (zero_count)
    );

    // gather target word and occupancy from the row
    always_comb
    begin
        hit_word = '0;
        any_occ  = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_flags[i].hit)
                hit_word = hit_word | cell_word[i];
            if (cell_flags[i].in_use && !cell_flags[i].empty)
                any_occ = 1'b1;
        end
    end

    assign tgt_occ  = hit_word != '0;
    assign idx_ok   = CMP_W'(idx_reg) < CMP_W'(n);
    assign idx_last = CMP_W'(idx_reg) == (CMP_W'(n) - CMP_W'(1));

    // command decode and status
    always_comb
    begin
        op_next     = fair_pkg::OP_HOLD;
        data_next   = value_reg;
        status_next = fair_pkg::ST_OK;
        rd_next     = '0;
        case (kind_reg)
            fair_pkg::KIND_LOAD:
                if (!idx_ok)
                    status_next = fair_pkg::ST_RANGE;
                else
                    op_next = fair_pkg::OP_WRITE;
            fair_pkg::KIND_FILL:
                op_next = fair_pkg::OP_FILL;
            fair_pkg::KIND_REM_VAL:
                if (value_reg == '0)
                    status_next = fair_pkg::ST_ZERO;
                else if (!any_occ)
                    status_next = fair_pkg::ST_NOTHING;
                else
                    op_next = fair_pkg::OP_CLEAR_MATCH;
            fair_pkg::KIND_REM_IDX:
                if (!idx_ok)
                    status_next = fair_pkg::ST_RANGE;
                else if (!tgt_occ)
                    status_next = fair_pkg::ST_ZERO;
                else
                begin
                    op_next   = fair_pkg::OP_WRITE;
                    data_next = '0;
                end
            fair_pkg::KIND_ADD:
                if (value_reg == '0)
                    status_next = fair_pkg::ST_ZERO;
                else if (!idx_ok)
                    status_next = fair_pkg::ST_RANGE;
                else if (!tgt_occ || mode_reg == fair_pkg::MODE_OVER)
                    op_next = fair_pkg::OP_WRITE;
                else if (mode_reg == fair_pkg::MODE_SHIFT_L)
                begin
                    if (idx_reg == '0)
                        status_next = fair_pkg::ST_MODE;
                    else
                        op_next = fair_pkg::OP_SHIFT_L;
                end
                else if (mode_reg == fair_pkg::MODE_SHIFT_R)
                begin
                    if (idx_last)
                        status_next = fair_pkg::ST_MODE;
                    else
                        op_next = fair_pkg::OP_SHIFT_R;
                end
                else
                    status_next = fair_pkg::ST_MODE;
            fair_pkg::KIND_READ:
                if (!idx_ok)
                    status_next = fair_pkg::ST_RANGE;
                else
                    rd_next = 32'(signed'(hit_word));
            default:
                status_next = fair_pkg::ST_MODE;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_accept)
                    state_next = S_EVAL;
            S_EVAL:
                state_next = S_APPLY;
            S_APPLY:
                state_next = S_CNT1;
            S_CNT1:
                state_next = S_CNT2;
            S_CNT2:
                state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // state, captured request and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_len_reg <= USED_LEN_RESET;
            kind_reg     <= '0;
            idx_reg      <= '0;
            value_reg    <= '0;
            mode_reg     <= '0;
            op_reg       <= fair_pkg::OP_HOLD;
            data_reg     <= '0;
            status_reg   <= '0;
            rd_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            m_status_reg <= '0;
            m_count_reg  <= '0;
            m_read_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
                used_len_reg <= cfg_wdata;
            if (s_accept)
            begin
                kind_reg  <= s_tdata[2:0];
                idx_reg   <= s_tdata[8:3];
                value_reg <= fair_pkg::WORD_BITS'(signed'(s_tdata[40:9]));
                mode_reg  <= s_tdata[42:41];
            end
            if (state_reg == S_EVAL)
            begin
                op_reg     <= op_next;
                data_reg   <= data_next;
                status_reg <= status_next;
                rd_reg     <= rd_next;
            end
            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
                m_status_reg <= status_reg;
                m_count_reg  <= 7'(zero_count);
                m_read_reg   <= rd_reg;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_read_reg, m_count_reg, m_status_reg};

    `FAIR_ASSERT(a_eval_follows_accept, (state_reg == S_EVAL) |-> $past(s_tvalid && s_tready), "evaluate without a captured request")
    `FAIR_ASSERT(a_row_moves_in_apply, (cell_cmd.op != fair_pkg::OP_HOLD) |-> (state_reg == S_APPLY), "cell row changed outside apply")
    `FAIR_ASSERT(a_result_from_done, $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE), "result loaded before count settled")
    `FAIR_ASSERT_ALWAYS(a_no_left_shift_at_zero, (state_reg == S_APPLY && op_reg == fair_pkg::OP_SHIFT_L) |-> (idx_reg != '0), "left shift issued at slot zero")

endmodule

`default_nettype wire

// ===== design/fair_cell.sv =====
`default_nettype none

module fair_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [fair_pkg::IDX_W-1:0]  cell_idx,
    input  wire fair_pkg::cell_cmd_t         cmd,
    input  wire fair_pkg::word_t             left_word,
    input  wire fair_pkg::word_t             right_word,
    output fair_pkg::word_t                  word,
    output fair_pkg::cell_flags_t            flags
);

    fair_pkg::word_t word_reg;
    fair_pkg::word_t word_next;
    logic            in_use;
    logic            hit;
    logic            below;
    logic            above;

    // position of this cell against the command
    assign in_use = fair_pkg::LEN_W'(cell_idx) < cmd.len;
    assign hit    = cmd.idx == cell_idx;
    assign below  = cell_idx < cmd.idx;
    assign above  = cell_idx > cmd.idx;

    // next slot content
    always_comb
    begin
        word_next = word_reg;
        case (cmd.op)
            fair_pkg::OP_HOLD:
                word_next = word_reg;
            fair_pkg::OP_WRITE:
                if (hit)
                    word_next = cmd.data;
            fair_pkg::OP_FILL:
                if (in_use)
                    word_next = cmd.data;
            fair_pkg::OP_CLEAR_MATCH:
                if (in_use && word_reg == cmd.data)
                    word_next = '0;
            fair_pkg::OP_SHIFT_L:
                if (hit)
                    word_next = cmd.data;
                else if (below)
                    word_next = right_word;
            fair_pkg::OP_SHIFT_R:
                if (hit)
                    word_next = cmd.data;
                else if (above && in_use)
                    word_next = left_word;
            default:
                word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign word         = word_reg;
    assign flags.in_use = in_use;
    assign flags.hit    = hit;
    assign flags.empty  = in_use && (word_reg == '0);

endmodule

`default_nettype wire

// ===== design/fair_zcount.sv =====
`default_nettype none

module fair_zcount (
    input  wire logic                         clk,
    input  wire logic [fair_pkg::DEPTH-1:0]   empty_vec,
    output logic      [fair_pkg::LEN_W-1:0]   count
);

    localparam int PAD_W = fair_pkg::NGROUP * fair_pkg::GROUP;

    logic [PAD_W-1:0]                 padded;
    logic [fair_pkg::GCNT_W-1:0]      group_next [fair_pkg::NGROUP];
    logic [fair_pkg::GCNT_W-1:0]      group_reg  [fair_pkg::NGROUP];
    logic [fair_pkg::LEN_W-1:0]       count_next;
    logic [fair_pkg::LEN_W-1:0]       count_reg;

    assign padded = PAD_W'(empty_vec);

    // first level: one count per group of eight cells
    always_comb
    begin
        for (int g = 0; g < fair_pkg::NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int b = 0; b < fair_pkg::GROUP; b++)
                group_next[g] = group_next[g]
                              + fair_pkg::GCNT_W'(padded[g*fair_pkg::GROUP + b]);
        end
    end

    // second level: sum of the group counts
    always_comb
    begin
        count_next = '0;
        for (int g = 0; g < fair_pkg::NGROUP; g++)
            count_next = count_next + fair_pkg::LEN_W'(group_reg[g]);
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
        count_reg <= count_next;
    end

    assign count = count_reg;

endmodule

`default_nettype wire
